[hw/rtl/page_bitmap_allocator_top_assert.svh]
// Assertion macros for the page bitmap allocator.
`ifndef PAGE_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTH

`define PBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pba assertion failed");

`define PBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pba assertion failed");

`else

`define PBA_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define PBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/pba_pkg.sv]
package pba_pkg;

    localparam int PAGE_COUNT = 65536;
    localparam int WORD_W     = 64;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WORD_COUNT = (PAGE_COUNT + WORD_W - 1) / WORD_W;
    localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CNT_W      = WORD_AW + 1;
    localparam int PAGE_W     = WORD_AW + BIT_W;
    localparam int IDX_W      = 16;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_MARK  = 2'd3
    } pba_action_t;

    typedef struct packed {
        pba_action_t      action;
        logic [IDX_W-1:0] page_index;
    } pba_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] result_page;
        logic             page_used;
        logic             full_res;
    } pba_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_SCAN
    } pba_state_t;

endpackage

[hw/rtl/pba_ram.sv]
module pba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/page_bitmap_allocator_top.sv]
// First-fit page allocator over a used/free bitmap held in one RAM of
// WORD_COUNT words of 64 bits (1024 words for 65536 pages). After reset the
// block clears the RAM, one word a cycle, with busy
// high. A command is taken when start is high and busy is low. Free and
// mark-used read one word and write it back; query only reads it. The result
// appears after the READ and UPDATE states, and busy drops in the same cycle.
// Allocate walks the bitmap one word per cycle through the RAM read port and
// stops at the first word with a free page, or after the last word when the
// bitmap is full. Each result is shown on rsp for exactly one cycle with done
// high; the receiver cannot stall it.
module page_bitmap_allocator_top
    import pba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  pba_req_t req,
    output logic     busy,
    output logic     done,
    output pba_rsp_t rsp
);

    `include "page_bitmap_allocator_top_assert.svh"

    pba_state_t          state_reg, state_next;
    pba_req_t            req_reg, req_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [WORD_AW-1:0]  rd_addr_reg, rd_addr_next;
    logic                pend_reg, pend_next;
    pba_rsp_t            rsp_reg, rsp_next;
    logic                done_reg, done_next;

    logic                ram_we;
    logic [WORD_AW-1:0]  ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [WORD_AW-1:0]  ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic [31:0]         idx32;
    logic [WORD_AW-1:0]  word_sel;
    logic [BIT_W-1:0]    bit_sel;
    logic                page_ok;
    logic [WORD_W-1:0]   bit_mask;
    logic [BIT_W-1:0]    free_pos;
    logic [PAGE_W-1:0]   free_page;

    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        logic [BIT_W-1:0]  pos;
        int                half;
        v   = ~w;
        pos = '0;
        for (int k = BIT_W - 1; k >= 0; k--)
        begin
            half = 1 << k;
            if ((v & ((WORD_W'(1) << half) - WORD_W'(1))) == '0)
            begin
                v   = v >> half;
                pos = pos | BIT_W'(half);
            end
        end
        return pos;
    endfunction

    pba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx32     = 32'(req_reg.page_index);
    assign word_sel  = idx32[BIT_W +: WORD_AW];
    assign bit_sel   = idx32[BIT_W-1:0];
    assign page_ok   = idx32 < 32'(PAGE_COUNT);
    assign bit_mask  = WORD_W'(1) << bit_sel;
    assign free_pos  = first_zero(ram_rdata);
    assign free_page = {rd_addr_reg, free_pos};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        rd_addr_reg <= rd_addr_next;
        rsp_reg     <= rsp_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        rd_addr_next = rd_addr_reg;
        pend_next    = 1'b0;
        rsp_next     = rsp_reg;
        done_next    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[WORD_AW-1:0];
                if (cnt_reg == CNT_W'(WORD_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    cnt_next = '0;
                    if (req.action == ACT_ALLOC)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                ram_raddr  = word_sel;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                rsp_next.result_page = req_reg.page_index;
                rsp_next.page_used   = 1'b0;
                rsp_next.full_res    = 1'b0;
                done_next            = 1'b1;
                state_next           = ST_IDLE;
                ram_waddr            = word_sel;
                if (page_ok)
                begin
                    unique case (req_reg.action)
                        ACT_FREE:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata & ~bit_mask;
                        end
                        ACT_MARK:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata | bit_mask;
                        end
                        ACT_QUERY:
                        begin
                            rsp_next.page_used = ram_rdata[bit_sel];
                        end
                        ACT_ALLOC:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && (ram_rdata != '1))
                begin
                    done_next          = 1'b1;
                    state_next         = ST_IDLE;
                    rsp_next.page_used = 1'b0;
                    if (32'(free_page) < 32'(PAGE_COUNT))
                    begin
                        ram_we               = 1'b1;
                        ram_waddr            = rd_addr_reg;
                        ram_wdata            = ram_rdata | (WORD_W'(1) << free_pos);
                        rsp_next.result_page = IDX_W'(free_page);
                        rsp_next.full_res    = 1'b0;
                    end
                    else
                    begin
                        rsp_next.result_page = '0;
                        rsp_next.full_res    = 1'b1;
                    end
                end
                else if (pend_reg && (rd_addr_reg == WORD_AW'(WORD_COUNT - 1)))
                begin
                    done_next            = 1'b1;
                    state_next           = ST_IDLE;
                    rsp_next.result_page = '0;
                    rsp_next.page_used   = 1'b0;
                    rsp_next.full_res    = 1'b1;
                end
                else if (cnt_reg < CNT_W'(WORD_COUNT))
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = cnt_reg[WORD_AW-1:0];
                    rd_addr_next = cnt_reg[WORD_AW-1:0];
                    pend_next    = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `PBA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `PBA_ASSERT_IMP(a_done_after_busy, clk, rst_n, done, $past(busy))
    `PBA_ASSERT_IMP(a_full_clean, clk, rst_n, done && rsp.full_res, (rsp.result_page == '0) && !rsp.page_used)
    `PBA_ASSERT_IMP(a_write_busy, clk, rst_n, ram_we, busy)

endmodule
